FILE: hw/rtl/script_token_scanner_macros.svh
// Assertion macros shared by the scanner modules.
// In synthesis builds the macros expand to nothing.
`ifndef SCRIPT_TOKEN_SCANNER_MACROS_SVH
`define SCRIPT_TOKEN_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
`define STS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define STS_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);
`else
`define STS_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define STS_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif
`endif

FILE: hw/rtl/sts_pkg.sv
`timescale 1ns / 1ps
package sts_pkg;

  // Raw classes of tokens held in the pending queue.
  localparam logic [1:0] RAW_FINAL = 2'd0;
  localparam logic [1:0] RAW_OP    = 2'd1;
  localparam logic [1:0] RAW_NUM   = 2'd2;

  localparam logic [4:0] KIND_STRING  = 5'd0;
  localparam logic [4:0] KIND_OP      = 5'd1;
  localparam logic [4:0] KIND_IDENT   = 5'd2;
  localparam logic [4:0] KIND_KW_BASE = 5'd3;
  localparam logic [4:0] KIND_AND     = 5'd10;
  localparam logic [4:0] KIND_OR      = 5'd11;
  localparam logic [4:0] KIND_NOT     = 5'd12;
  localparam logic [4:0] KIND_EQ      = 5'd13;
  localparam logic [4:0] KIND_NEQ     = 5'd14;
  localparam logic [4:0] KIND_LESS    = 5'd15;
  localparam logic [4:0] KIND_GREATER = 5'd16;
  localparam logic [4:0] KIND_LEQ     = 5'd17;
  localparam logic [4:0] KIND_GEQ     = 5'd18;
  localparam logic [4:0] KIND_DOUBLE  = 5'd20;
  localparam logic [4:0] KIND_INT     = 5'd21;
  localparam logic [4:0] KIND_ERROR   = 5'd22;

  localparam int REC_DEPTH = 4;
  localparam int KW_COUNT  = 17;

  // Keyword text, first character in the low byte, and its length.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h6669, 64'h65736c65, 64'h726f66, 64'h656c696877, 64'h6e7275746572,
    64'h6b61657262, 64'h65756e69746e6f63, 64'h646e61, 64'h726f, 64'h746f6e,
    64'h7165, 64'h71656e, 64'h7373656c, 64'h72657461657267, 64'h71656c,
    64'h716567, 64'h6c61626f6c67
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd4, 4'd3, 4'd5, 4'd6, 4'd5, 4'd8, 4'd3, 4'd2, 4'd3,
    4'd2, 4'd3, 4'd4, 4'd7, 4'd3, 4'd3, 4'd6
  };

  typedef enum logic [1:0] {ACT_NONE, ACT_PUSH, ACT_ERR} act_kind_t;

  typedef struct packed {
    logic [1:0]  raw;
    logic [4:0]  kind;
    logic [7:0]  op;
    logic        ends_e;
    logic [15:0] line;
    logic [15:0] start;
    logic [15:0] len;
  } tok_t;

  typedef struct packed {
    act_kind_t what;
    tok_t      tok;
  } act_t;

  // Everything one source byte asks of the back end.
  typedef struct packed {
    act_t a0;
    act_t a1;
    logic fin;
  } rec_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [4:0] kw_kind(input logic [63:0] prefix, input logic [15:0] len);
    logic [4:0] k;
    k = KIND_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (len == 16'(KW_LEN[i]) && prefix == KW_TEXT[i]) k = KIND_KW_BASE + 5'(i);
    end
    return k;
  endfunction

  function automatic logic mergeable(input logic [7:0] c);
    return c == "!" || c == "=" || c == "&" || c == "|" || c == "<" || c == ">";
  endfunction

  function automatic logic [4:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] k;
    k = KIND_STRING;
    if (b == "=") begin
      case (a)
        "!": k = KIND_NEQ;
        "=": k = KIND_EQ;
        "<": k = KIND_LEQ;
        ">": k = KIND_GEQ;
        default: k = KIND_STRING;
      endcase
    end
    if (a == "&" && b == "&") k = KIND_AND;
    if (a == "|" && b == "|") k = KIND_OR;
    return k;
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "!": k = KIND_NOT;
      "<": k = KIND_LESS;
      ">": k = KIND_GREATER;
      default: k = KIND_OP;
    endcase
    return k;
  endfunction

  function automatic tok_t mk_tok(input logic [1:0] raw, input logic [4:0] kind,
                                  input logic [7:0] op, input logic ends_e,
                                  input logic [15:0] line, input logic [15:0] start,
                                  input logic [15:0] len);
    tok_t t;
    t.raw = raw; t.kind = kind; t.op = op; t.ends_e = ends_e;
    t.line = line; t.start = start; t.len = len;
    return t;
  endfunction

endpackage

FILE: hw/rtl/sts_front.sv
`timescale 1ns / 1ps
module sts_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    in_byte,
  input  logic          in_end,
  output logic          rec_wr,
  output sts_pkg::rec_t rec
);

  localparam int PosW = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  typedef enum logic [1:0] {W_NONE, W_IDENT, W_NUM, W_ERR} wcls_t;

  logic [63:0]     prefix_r, prefix_nxt;
  logic [15:0]     start_r, start_nxt, len_r, len_nxt, line_r, line_nxt;
  wcls_t           cls_r, cls_nxt;
  logic            dot_r, dot_nxt, str_r, str_nxt, cmt_r, cmt_nxt;
  logic [7:0]      prev_r, prev_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;

  function automatic sts_pkg::act_t end_word(input wcls_t cls, input logic [63:0] prefix,
                                             input logic [15:0] start, input logic [15:0] len,
                                             input logic dot, input logic [7:0] prev,
                                             input logic [15:0] line);
    sts_pkg::act_t a;
    a.what = sts_pkg::ACT_NONE;
    a.tok  = '0;
    case (cls)
      W_IDENT: begin
        a.what = sts_pkg::ACT_PUSH;
        a.tok  = sts_pkg::mk_tok(sts_pkg::RAW_FINAL, sts_pkg::kw_kind(prefix, len), 8'd0,
                                 1'b0, line, start, len);
      end
      W_NUM: begin
        a.what = sts_pkg::ACT_PUSH;
        a.tok  = sts_pkg::mk_tok(sts_pkg::RAW_NUM,
                                 dot ? sts_pkg::KIND_DOUBLE : sts_pkg::KIND_INT, 8'd0,
                                 prev == "e" || prev == "E", line, start, len);
      end
      W_ERR: begin
        a.what = sts_pkg::ACT_ERR;
        a.tok  = sts_pkg::mk_tok(sts_pkg::RAW_FINAL, sts_pkg::KIND_ERROR, 8'd0, 1'b0,
                                 line, start, len);
      end
      default: a.what = sts_pkg::ACT_NONE;
    endcase
    return a;
  endfunction

  sts_pkg::act_t a_word, a_tok, a_end;
  logic          handle;
  logic [7:0]    c;
  logic [15:0]   pos16;

  always_comb begin
    prefix_nxt = prefix_r; start_nxt = start_r; len_nxt = len_r; line_nxt = line_r;
    cls_nxt = cls_r; dot_nxt = dot_r; str_nxt = str_r; cmt_nxt = cmt_r;
    prev_nxt = prev_r;
    a_word = '0; a_tok = '0; a_end = '0;
    handle = 1'b1;
    pos16  = 16'(pos_r);
    pos_nxt = (pos_r != PosMax) ? pos_r + 1'b1 : pos_r;

    if (cmt_r) begin
      if (in_byte == 8'h0A) cmt_nxt = 1'b0;
      else handle = 1'b0;
    end else if (in_byte == "#") begin
      cmt_nxt = 1'b1;
      handle  = 1'b0;
    end

    // An escaped double quote is taken as an apostrophe.
    c = (in_byte == 8'h22 && prev_r == 8'h5C) ? 8'h27 : in_byte;

    if (handle) begin
      if (str_r) begin
        if (c == 8'h22) begin
          a_tok.what = sts_pkg::ACT_PUSH;
          a_tok.tok  = sts_pkg::mk_tok(sts_pkg::RAW_FINAL, sts_pkg::KIND_STRING, 8'd0, 1'b0,
                                       line_r, start_r, len_r);
          str_nxt = 1'b0; start_nxt = '0; len_nxt = '0;
        end else begin
          if (c == 8'h0A) line_nxt = sts_pkg::sat_add16(line_r, 16'd1);
          len_nxt = sts_pkg::sat_add16(len_r, 16'd1);
        end
      end else if (c inside {8'h22, 8'h20, 8'h09, 8'h0D, 8'h0A,
                             "=", "+", "-", "*", "/", "%", "^", "{", "}", "[", "]",
                             "(", ")", ";", ",", ":", "!", "<", ">", "&", "|"}) begin
        a_word = end_word(cls_r, prefix_r, start_r, len_r, dot_r, prev_r, line_r);
        cls_nxt = W_NONE; prefix_nxt = '0; start_nxt = '0; len_nxt = '0; dot_nxt = 1'b0;
        case (c)
          8'h22: begin
            str_nxt   = 1'b1;
            start_nxt = (pos_r != PosMax) ? pos16 + 16'd1 : pos16;
          end
          8'h20, 8'h09, 8'h0D: ;
          8'h0A: line_nxt = sts_pkg::sat_add16(line_r, 16'd1);
          default: begin
            a_tok.what = sts_pkg::ACT_PUSH;
            a_tok.tok  = sts_pkg::mk_tok(sts_pkg::RAW_OP, sts_pkg::KIND_OP, c, 1'b0,
                                         line_r, pos16, 16'd1);
          end
        endcase
      end else begin
        if (cls_r == W_NONE) begin
          start_nxt = pos16;
          if ((c | 8'h20) inside {["a":"z"]} || c == "_") cls_nxt = W_IDENT;
          else if (c inside {["0":"9"]}) cls_nxt = W_NUM;
          else cls_nxt = W_ERR;
        end
        for (int i = 0; i < 8; i++) begin
          if (len_r < 16'd8 && len_r[2:0] == 3'(i)) prefix_nxt[8*i +: 8] = prefix_r[8*i +: 8] | c;
        end
        len_nxt = sts_pkg::sat_add16(len_r, 16'd1);
        if (c == "." || c == "e" || c == "E") dot_nxt = 1'b1;
      end
      prev_nxt = c;
    end

    if (in_end) begin
      if (!str_nxt)
        a_end = end_word(cls_nxt, prefix_nxt, start_nxt, len_nxt, dot_nxt, prev_nxt, line_nxt);
      prefix_nxt = '0; start_nxt = '0; len_nxt = '0; line_nxt = 16'd1;
      cls_nxt = W_NONE; dot_nxt = 1'b0; str_nxt = 1'b0; cmt_nxt = 1'b0;
      prev_nxt = '0; pos_nxt = '0;
    end

    // At most two actions are ever live, and they keep their order.
    if (a_word.what != sts_pkg::ACT_NONE) begin
      rec.a0 = a_word;
      rec.a1 = a_tok;
    end else if (a_tok.what != sts_pkg::ACT_NONE) begin
      rec.a0 = a_tok;
      rec.a1 = '0;
    end else begin
      rec.a0 = a_end;
      rec.a1 = '0;
    end
    rec.fin = in_end;
    rec_wr  = take && (rec.a0.what != sts_pkg::ACT_NONE || in_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0; start_r <= '0; len_r <= '0; line_r <= 16'd1;
      cls_r <= W_NONE; dot_r <= 1'b0; str_r <= 1'b0; cmt_r <= 1'b0;
      prev_r <= '0; pos_r <= '0;
    end else if (take) begin
      prefix_r <= prefix_nxt; start_r <= start_nxt; len_r <= len_nxt; line_r <= line_nxt;
      cls_r <= cls_nxt; dot_r <= dot_nxt; str_r <= str_nxt; cmt_r <= cmt_nxt;
      prev_r <= prev_nxt; pos_r <= pos_nxt;
    end
  end

endmodule

FILE: hw/rtl/sts_fifo.sv
`timescale 1ns / 1ps
`include "script_token_scanner_macros.svh"
module sts_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  sts_pkg::rec_t wdata,
  output logic          full,
  input  logic          rd,
  output sts_pkg::rec_t rdata,
  output logic          empty
);

  localparam int PW = $clog2(sts_pkg::REC_DEPTH);

  sts_pkg::rec_t mem_r [sts_pkg::REC_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = cnt_r == (PW+1)'(sts_pkg::REC_DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

  `STS_NEVER(a_fifo_overflow, clk, rst_n, wr && full && !rd, "record queue overflow")
  `STS_NEVER(a_fifo_underflow, clk, rst_n, rd && empty, "record queue read while empty")

endmodule

FILE: hw/rtl/sts_back.sv
`timescale 1ns / 1ps
`include "script_token_scanner_macros.svh"
module sts_back #(
  parameter int PENDING_DEPTH = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rec_v,
  input  sts_pkg::rec_t rec,
  output logic          rec_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [4:0]    out_token_kind,
  output logic [7:0]    out_op_char,
  output logic [15:0]   out_line_number,
  output logic [15:0]   out_start_offset,
  output logic [15:0]   out_text_length,
  output logic          out_last_of_run,
  output logic          out_stream_done
);

  localparam int CW = $clog2(PENDING_DEPTH + 1);

  typedef enum logic [1:0] {PH_A0, PH_A1, PH_FIN} phase_t;

  sts_pkg::tok_t q_r [PENDING_DEPTH];
  sts_pkg::tok_t qv [PENDING_DEPTH];
  sts_pkg::tok_t q_nxt [PENDING_DEPTH];
  logic [CW-1:0] cnt_r, nv, cnt_nxt;
  phase_t        ph_r, eph, ph_nxt;
  logic          pushed_r;

  sts_pkg::act_t cur;
  logic          fin_res, do_push, emit_v, ph_done, rec_done, back_go, out_free, hold_move;
  logic [1:0]    used;
  logic [4:0]    pk;
  sts_pkg::tok_t e;

  // Held token: its last flag is known once the next token or the record end arrives.
  logic          hold_v_r, hold_known_r, hold_done_r;
  sts_pkg::tok_t hold_r;
  logic          out_v_r, out_last_r, out_done_r;
  sts_pkg::tok_t out_r;

  always_comb begin
    eph = (ph_r == PH_A0 && rec.a0.what == sts_pkg::ACT_NONE) ? PH_FIN : ph_r;
    case (eph)
      PH_A0:   cur = rec.a0;
      PH_A1:   cur = rec.a1;
      default: cur = '0;
    endcase
    fin_res = eph == PH_FIN && rec.fin;
    do_push = cur.what == sts_pkg::ACT_PUSH && !pushed_r && cnt_r < CW'(PENDING_DEPTH);
    for (int i = 0; i < PENDING_DEPTH; i++)
      qv[i] = (do_push && cnt_r == CW'(i)) ? cur.tok : q_r[i];
    nv = cnt_r + CW'(do_push);

    emit_v = 1'b0; ph_done = 1'b0; used = 2'd0; pk = sts_pkg::KIND_STRING;
    e = qv[0];
    if (cur.what == sts_pkg::ACT_ERR) begin
      emit_v = 1'b1; e = cur.tok; ph_done = 1'b1;
    end else if (eph == PH_FIN && !rec.fin) begin
      ph_done = 1'b1;
    end else if (nv == '0) begin
      ph_done = 1'b1;
    end else if (qv[0].raw == sts_pkg::RAW_NUM && qv[0].ends_e) begin
      e.kind = sts_pkg::KIND_DOUBLE;
      if (nv < CW'(2) && !fin_res) begin
        ph_done = 1'b1;
      end else if (nv >= CW'(2) && qv[1].raw == sts_pkg::RAW_NUM) begin
        emit_v = 1'b1; used = 2'd2;
        e.len  = sts_pkg::sat_add16(qv[0].len, qv[1].len);
      end else if (nv >= CW'(2) && qv[1].raw == sts_pkg::RAW_OP) begin
        if (nv < CW'(3)) begin
          if (!fin_res) ph_done = 1'b1;
          else begin
            emit_v = 1'b1; used = 2'd1;
          end
        end else begin
          emit_v = 1'b1; used = 2'd3;
          e.len  = sts_pkg::sat_add16(sts_pkg::sat_add16(qv[0].len, qv[1].len), qv[2].len);
        end
      end else begin
        emit_v = 1'b1; used = 2'd1;
      end
    end else if (qv[0].raw == sts_pkg::RAW_OP && sts_pkg::mergeable(qv[0].op)) begin
      if (nv < CW'(2) && !fin_res) begin
        ph_done = 1'b1;
      end else begin
        if (nv >= CW'(2) && qv[1].raw == sts_pkg::RAW_OP) pk = sts_pkg::pair_kind(qv[0].op, qv[1].op);
        emit_v = 1'b1;
        if (pk != sts_pkg::KIND_STRING) begin
          used = 2'd2; e.kind = pk;
          e.len = sts_pkg::sat_add16(qv[0].len, qv[1].len);
        end else begin
          used = 2'd1; e.kind = sts_pkg::single_kind(qv[0].op);
        end
      end
    end else begin
      emit_v = 1'b1; used = 2'd1;
    end

    for (int i = 0; i < PENDING_DEPTH; i++) begin
      q_nxt[i] = qv[i];
      if (i + int'(used) < PENDING_DEPTH) q_nxt[i] = qv[i + int'(used)];
    end
    cnt_nxt = nv - CW'(used);

    rec_done = 1'b0;
    ph_nxt   = eph;
    if (ph_done) begin
      case (eph)
        PH_A0: begin
          if (rec.a1.what != sts_pkg::ACT_NONE) ph_nxt = PH_A1;
          else if (rec.fin) ph_nxt = PH_FIN;
          else rec_done = 1'b1;
        end
        PH_A1: begin
          if (rec.fin) ph_nxt = PH_FIN;
          else rec_done = 1'b1;
        end
        default: rec_done = 1'b1;
      endcase
    end

    out_free  = !out_v_r || !out_stall;
    back_go   = rec_v && !(emit_v && hold_v_r && !out_free);
    rec_pop   = back_go && rec_done;
    hold_move = hold_v_r && out_free && (hold_known_r || (emit_v && back_go));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; ph_r <= PH_A0; pushed_r <= 1'b0;
      hold_v_r <= 1'b0; hold_known_r <= 1'b0; hold_done_r <= 1'b0;
      out_v_r <= 1'b0; out_last_r <= 1'b0; out_done_r <= 1'b0;
    end else begin
      if (back_go) begin
        for (int i = 0; i < PENDING_DEPTH; i++) q_r[i] <= q_nxt[i];
        cnt_r    <= (rec_done && rec.fin) ? '0 : cnt_nxt;
        ph_r     <= rec_done ? PH_A0 : ph_nxt;
        pushed_r <= !ph_done;
      end

      if (hold_move) begin
        out_v_r    <= 1'b1;
        out_r      <= hold_r;
        out_last_r <= hold_known_r;
        out_done_r <= hold_known_r && hold_done_r;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end

      if (back_go && emit_v) begin
        hold_v_r     <= 1'b1;
        hold_r       <= e;
        hold_known_r <= rec_done;
        hold_done_r  <= rec_done && rec.fin;
      end else if (hold_move) begin
        hold_v_r     <= 1'b0;
        hold_known_r <= 1'b0;
      end else if (back_go && rec_done && hold_v_r && !hold_known_r) begin
        hold_known_r <= 1'b1;
        hold_done_r  <= rec.fin;
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_token_kind   = out_r.kind;
  assign out_op_char      = (out_r.kind == sts_pkg::KIND_OP) ? out_r.op : 8'd0;
  assign out_line_number  = out_r.line;
  assign out_start_offset = out_r.start;
  assign out_text_length  = out_r.len;
  assign out_last_of_run  = out_last_r;
  assign out_stream_done  = out_done_r;

  `STS_NEVER(a_pending_bound, clk, rst_n, back_go && cnt_nxt > CW'(3), "pending queue above three")
  `STS_ASSERT(a_hold_known, clk, rst_n, hold_known_r |-> hold_v_r, "hold flagged without token")
  `STS_ASSERT(a_done_is_last, clk, rst_n, out_v_r && out_done_r |-> out_last_r, "done not last")

endmodule

FILE: hw/rtl/script_token_scanner.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Word
// in_       input      in_valid/in_stall   in_byte, in_end_of_input
// out_      output     out_valid/out_stall token fields, last_of_run, stream_done
//
// The front end classifies one byte per cycle and writes a record of up to two
// token actions into a four-entry record queue; a byte is taken whenever that
// queue has room. The back end works through each record's push actions and its
// end-of-input flush in turn, emitting tokens as merges resolve (an error word is
// emitted and closed together), while the queue absorbs the burst.
// Reset is synchronous and active low; it clears all control state at once.
// A stalled output word holds its register; the back end waits only when it has a
// token to emit while a token is held and the output register holds a stalled word.
module script_token_scanner #(
  parameter int OFFSET_BITS   = 16,
  parameter int PENDING_DEPTH = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_kind,
  output logic [7:0]  out_op_char,
  output logic [15:0] out_line_number,
  output logic [15:0] out_start_offset,
  output logic [15:0] out_text_length,
  output logic        out_last_of_run,
  output logic        out_stream_done
);

  logic          take, rec_wr, fifo_full, fifo_empty, rec_pop;
  sts_pkg::rec_t rec_in, rec_out;

  // The front end stalls only on a full record queue.
  assign in_stall = fifo_full;
  assign take     = in_valid && !fifo_full;

  sts_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_byte),
    .in_end  (in_end_of_input),
    .rec_wr  (rec_wr),
    .rec     (rec_in)
  );

  sts_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (rec_wr),
    .wdata (rec_in),
    .full  (fifo_full),
    .rd    (rec_pop),
    .rdata (rec_out),
    .empty (fifo_empty)
  );

  // The back end keeps and merges pending tokens, one token a cycle unless stalled.
  sts_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .rec_v            (!fifo_empty),
    .rec              (rec_out),
    .rec_pop          (rec_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_op_char      (out_op_char),
    .out_line_number  (out_line_number),
    .out_start_offset (out_start_offset),
    .out_text_length  (out_text_length),
    .out_last_of_run  (out_last_of_run),
    .out_stream_done  (out_stream_done)
  );

endmodule
